@@ rtl/esd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esd_pkg
// shared types and constants of the seconds-to-date converter
// ----------------------------------------------------------------------------
package esd_pkg;

    localparam logic [31:0] ZONE_OFFSET  = 32'd3600;
    localparam logic [31:0] LOCAL_SAT    = 32'hffff_ffff;
    localparam int unsigned LEAP_COUNT   = 33;
    localparam logic [11:0] YEAR_BASE    = 12'd1970;
    localparam logic [11:0] YEAR_NO_LEAP = 12'd2100;

    // 86400 = 128 * 675, the 675 part by reciprocal
    localparam logic [9:0]  DAY_DIV_ODD  = 10'd675;
    localparam logic [22:0] DAY_RECIP    = 23'd6362914;   // floor(2^32 / 675)
    localparam logic [8:0]  YEAR_DAYS    = 9'd365;
    localparam logic [15:0] YEAR_RECIP   = 16'd45964;     // floor(2^24 / 365)

    localparam logic [15:0] LEAP_LAST_DAY [LEAP_COUNT] = '{
        16'd1095,  16'd2556,  16'd4017,  16'd5478,  16'd6939,  16'd8400,
        16'd9861,  16'd11322, 16'd12783, 16'd14244, 16'd15705, 16'd17166,
        16'd18627, 16'd20088, 16'd21549, 16'd23010, 16'd24471, 16'd25932,
        16'd27393, 16'd28854, 16'd30315, 16'd31776, 16'd33237, 16'd34698,
        16'd36159, 16'd37620, 16'd39081, 16'd40542, 16'd42003, 16'd43464,
        16'd44925, 16'd46386, 16'd49307
    };

    // first day-of-year index of each month
    localparam logic [9:0] MONTH_START_COMMON [12] = '{
        10'd0,   10'd31,  10'd59,  10'd90,  10'd120, 10'd151,
        10'd181, 10'd212, 10'd243, 10'd273, 10'd304, 10'd334
    };
    localparam logic [9:0] MONTH_START_LEAP [12] = '{
        10'd0,   10'd31,  10'd60,  10'd91,  10'd121, 10'd152,
        10'd182, 10'd213, 10'd244, 10'd274, 10'd305, 10'd335
    };

    typedef struct packed {
        logic advance;   // whole pipe moves one stage
        logic valid;     // beat present at stage input
    } stage_ctrl_t;

    typedef struct packed {
        logic [7:0] year_ofs;   // years since the base year
        logic [9:0] yday;       // zero-based day of year
    } year_beat_t;

endpackage : esd_pkg
`default_nettype wire

@@ rtl/esd_day_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esd_day_stage
// zone offset with saturation and division by 86400, three register stages
// ----------------------------------------------------------------------------
module esd_day_stage
    import esd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire stage_ctrl_t ctrl,
    input  wire logic [31:0] epoch_seconds,
    output logic             out_valid,
    output logic [15:0]      days
);

    logic        v1_reg, v2_reg, v3_reg;
    logic [31:0] local_reg, local_next;
    logic [24:0] x_reg;
    logic [15:0] q0_reg, q0_next;
    logic [15:0] days_reg, days_next;
    logic [32:0] sum;
    logic [47:0] recip_prod;
    logic [25:0] back_prod;
    logic [25:0] resid;

    // stage 1: add zone offset, saturate on carry out
    always_comb begin
        sum        = {1'b0, epoch_seconds} + {1'b0, ZONE_OFFSET};
        local_next = sum[32] ? LOCAL_SAT : sum[31:0];
    end

    // stage 2: estimate of (local / 128) / 675, low by at most one
    always_comb begin
        recip_prod = 48'(local_reg[31:7]) * 48'(DAY_RECIP);
        q0_next    = recip_prod[47:32];
    end

    // stage 3: one correction step
    always_comb begin
        back_prod = 26'(q0_reg) * 26'(DAY_DIV_ODD);
        resid     = {1'b0, x_reg} - back_prod;
        days_next = (resid >= 26'(DAY_DIV_ODD)) ? q0_reg + 16'd1 : q0_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (ctrl.advance) begin
            v1_reg <= ctrl.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            local_reg <= local_next;
            x_reg     <= local_reg[31:7];
            q0_reg    <= q0_next;
            days_reg  <= days_next;
        end
    end

    assign out_valid = v3_reg;
    assign days      = days_reg;

endmodule : esd_day_stage
`default_nettype wire

@@ rtl/esd_year_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esd_year_stage
// leap year count against the table, year offset and day of year
// ----------------------------------------------------------------------------
module esd_year_stage
    import esd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire stage_ctrl_t ctrl,
    input  wire logic [15:0] days,
    output logic             out_valid,
    output year_beat_t       beat
);

    logic        v1_reg, v2_reg, v3_reg;
    logic [15:0] days_reg;
    logic [5:0]  leaps_reg, leaps_next;
    logic        on_last1_reg, on_last1_next;
    logic [15:0] dl_reg;
    logic [7:0]  q0_reg;
    logic        on_last2_reg;
    logic [15:0] dl_next;
    logic [31:0] recip_prod;
    year_beat_t  beat_reg, beat_next;
    logic [15:0] back_prod;
    logic [15:0] resid;
    logic        wrap;
    logic [7:0]  q;
    logic [8:0]  r;

    // stage 1: parallel compare against every table entry
    always_comb begin
        leaps_next    = '0;
        on_last1_next = 1'b0;
        for (int i = 0; i < LEAP_COUNT; i++) begin
            leaps_next    = leaps_next + 6'(LEAP_LAST_DAY[i] < days);
            on_last1_next = on_last1_next | (LEAP_LAST_DAY[i] == days);
        end
    end

    // stage 2: estimate of (days - leaps) / 365
    always_comb begin
        dl_next    = days_reg - 16'(leaps_reg);
        recip_prod = 32'(dl_next) * 32'(YEAR_RECIP);
    end

    // stage 3: correction, then last day of a leap year stays in that year
    always_comb begin
        back_prod = 16'(q0_reg) * 16'(YEAR_DAYS);
        resid     = dl_reg - back_prod;
        wrap      = resid >= 16'(YEAR_DAYS);
        q         = wrap ? q0_reg + 8'd1 : q0_reg;
        r         = wrap ? 9'(resid - 16'(YEAR_DAYS)) : resid[8:0];
        if (on_last2_reg) begin
            beat_next.year_ofs = q - 8'd1;
            beat_next.yday     = 10'(r) + 10'(YEAR_DAYS);
        end else begin
            beat_next.year_ofs = q;
            beat_next.yday     = 10'(r);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (ctrl.advance) begin
            v1_reg <= ctrl.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            days_reg     <= days;
            leaps_reg    <= leaps_next;
            on_last1_reg <= on_last1_next;
            dl_reg       <= dl_next;
            q0_reg       <= recip_prod[31:24];
            on_last2_reg <= on_last1_reg;
            beat_reg     <= beat_next;
        end
    end

    assign out_valid = v3_reg;
    assign beat      = beat_reg;

endmodule : esd_year_stage
`default_nettype wire

@@ rtl/esd_month_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esd_month_stage
// year number, month and day of month, output register
// ----------------------------------------------------------------------------
module esd_month_stage
    import esd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire stage_ctrl_t ctrl,
    input  wire year_beat_t  beat,
    output logic             out_valid,
    output logic [11:0]      year,
    output logic [3:0]       month,
    output logic [4:0]       day
);

    logic        valid_reg;
    logic [11:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic        leap;
    logic [3:0]  m;
    logic [9:0]  start;

    always_comb begin
        year_next = YEAR_BASE + 12'(beat.year_ofs);
        leap      = (year_next[1:0] == 2'b00) && (year_next != YEAR_NO_LEAP);
        m         = '0;
        for (int k = 1; k < 12; k++) begin
            if (leap) begin
                m = m + 4'(beat.yday >= MONTH_START_LEAP[k]);
            end else begin
                m = m + 4'(beat.yday >= MONTH_START_COMMON[k]);
            end
        end
        start      = leap ? MONTH_START_LEAP[m] : MONTH_START_COMMON[m];
        month_next = m + 4'd1;
        day_next   = 5'(beat.yday - start + 10'd1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.advance) begin
            valid_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
        end
    end

    assign out_valid = valid_reg;
    assign year      = year_reg;
    assign month     = month_reg;
    assign day       = day_reg;

endmodule : esd_month_stage
`default_nettype wire

@@ rtl/epoch_seconds_to_date_core.sv @@
`default_nettype none
// an input beat passes the day, year and month stage registers on its way to m_
// throughput: one beat per cycle unless m_ready stalls; the seven stages move in lockstep
// a stall on m_ready freezes every stage and drops s_ready in the same cycle
// reset: synchronous active-low aresetn clears all stage valid bits
// ----------------------------------------------------------------------------
// epoch_seconds_to_date_core
// converts unsigned epoch seconds plus a fixed one-hour zone to year/month/day
// ----------------------------------------------------------------------------
module epoch_seconds_to_date_core
    import esd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // input beats
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_epoch_seconds,

    // result beats
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [11:0]      m_year,
    output logic [3:0]       m_month,
    output logic [4:0]       m_day
);

    logic        advance;
    logic        day_valid;
    logic [15:0] days;
    logic        year_valid;
    year_beat_t  year_beat;
    stage_ctrl_t day_ctrl, year_ctrl, month_ctrl;

    // the pipe moves whenever the output register is empty or being drained
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    assign day_ctrl   = '{advance: advance, valid: s_valid};
    assign year_ctrl  = '{advance: advance, valid: day_valid};
    assign month_ctrl = '{advance: advance, valid: year_valid};

    // stages 1-3: local time and day number
    esd_day_stage u_day (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (day_ctrl),
        .epoch_seconds (s_epoch_seconds),
        .out_valid     (day_valid),
        .days          (days)
    );

    // stages 4-6: leap count, year offset, day of year
    esd_year_stage u_year (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (year_ctrl),
        .days      (days),
        .out_valid (year_valid),
        .beat      (year_beat)
    );

    // stage 7: month walk folded into parallel compares, output register
    esd_month_stage u_month (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (month_ctrl),
        .beat      (year_beat),
        .out_valid (m_valid),
        .year      (m_year),
        .month     (m_month),
        .day       (m_day)
    );

    // results stay inside the calendar range
    a_year_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_year >= 12'd1970 && m_year <= 12'd2106))
        else $error("year out of range");

    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_month >= 4'd1 && m_month <= 4'd12))
        else $error("month out of range");

    a_day_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_day != 5'd0))
        else $error("day is zero");

    // a stalled result must hold the whole pipe
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted during output stall");

endmodule : epoch_seconds_to_date_core
`default_nettype wire
